FILE: rtl/core/a2i_pkg.sv
// ---------------------------------------------------------------------------
// a2i_pkg
// Shared types and constants for the ASCII to 64-bit integer parser.
// ---------------------------------------------------------------------------
`default_nettype none

package a2i_pkg;

  // Saturation limit of the consumed byte count
  localparam int unsigned MAX_CHARS = 4096;
  localparam int unsigned COUNT_W   = 13;
  localparam int unsigned BASE_W    = 5;

  typedef logic [7:0]         char_t;
  typedef logic [COUNT_W-1:0] count_t;
  typedef logic [BASE_W-1:0]  base_t;
  typedef logic signed [63:0] value_t;

endpackage : a2i_pkg

`default_nettype wire

FILE: rtl/core/a2i_if.sv
// ---------------------------------------------------------------------------
// a2i input and result channels
// Valid/ready channels carrying one text byte, or one parse result.
// ---------------------------------------------------------------------------
`default_nettype none

interface a2i_in_if;
  import a2i_pkg::*;

  logic  valid;
  logic  ready;
  char_t char_in;
  logic  start_string;

  modport source (output valid, output char_in, output start_string, input ready);
  modport sink   (input valid, input char_in, input start_string, output ready);
endinterface : a2i_in_if

interface a2i_out_if;
  import a2i_pkg::*;

  logic   valid;
  logic   ready;
  value_t parsed_value;
  count_t consumed_count;
  logic   overflowed;

  modport source (output valid, output parsed_value, output consumed_count,
                  output overflowed, input ready);
  modport sink   (input valid, input parsed_value, input consumed_count,
                  input overflowed, output ready);
endinterface : a2i_out_if

`default_nettype wire

FILE: rtl/core/ascii_to_int64_parser_top.sv
// ---------------------------------------------------------------------------
// ascii_to_int64_parser_top
// Byte-serial string to signed 64-bit integer converter (strtoll style).
// ---------------------------------------------------------------------------
//
//   Channel   | Dir | Handshake          | Carries
//   ----------+-----+--------------------+--------------------------------------
//   in_ch     | in  | valid / ready      | char_in, start_string
//   out_ch    | out | valid / ready      | parsed_value, consumed_count, overflowed
//   APB       | in  | psel/penable/pready| base_select at byte address 0
//
// One byte is taken per cycle; the whole parse step for a byte (phase
// decode, digit decode, multiply-by-base and overflow check) sits between
// the parse state registers and the result register. A result appears on
// out_ch the cycle after its stopping byte is transferred. in_ch stalls
// only while a result is held and out_ch is not ready. Reset (rst,
// synchronous) clears the phase to idle and drops any held result.
// ---------------------------------------------------------------------------
`default_nettype none

module ascii_to_int64_parser_top (
  input  wire logic               clk,
  input  wire logic               rst,
  a2i_in_if.sink                  in_ch,
  a2i_out_if.source               out_ch,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output      logic [31:0]        prdata,
  output      logic               pready
);
  import a2i_pkg::*;

  // Parse phases
  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_WS     = 3'd1;
  localparam logic [2:0] PH_PREFIX = 3'd2;
  localparam logic [2:0] PH_ZERO   = 3'd3;
  localparam logic [2:0] PH_DIGITS = 3'd4;
  localparam logic [2:0] PH_DONE   = 3'd5;

  localparam char_t CH_ZERO  = 8'h30;
  localparam char_t CH_NINE  = 8'h39;
  localparam char_t CH_LA    = 8'h61;
  localparam char_t CH_LF    = 8'h66;
  localparam char_t CH_UA    = 8'h41;
  localparam char_t CH_UF    = 8'h46;
  localparam char_t CH_LX    = 8'h78;
  localparam char_t CH_UX    = 8'h58;
  localparam char_t CH_PLUS  = 8'h2B;
  localparam char_t CH_MINUS = 8'h2D;
  localparam char_t CH_SPACE = 8'h20;
  localparam char_t CH_TAB   = 8'h09;
  localparam char_t CH_CR    = 8'h0D;

  localparam base_t BASE_AUTO = 5'd0;
  localparam base_t BASE_OCT  = 5'd8;
  localparam base_t BASE_DEC  = 5'd10;
  localparam base_t BASE_HEX  = 5'd16;

  localparam logic REG_BASE_SELECT = 1'b0;

  localparam count_t COUNT_MAX = COUNT_W'(MAX_CHARS);
  localparam value_t POS_MAX   = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam value_t NEG_MIN   = 64'sh8000_0000_0000_0000;

  // Digit value with a flag; the digit must lie below the active base
  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } digit_t;

  function automatic digit_t digit_of(input char_t c, input base_t b);
    digit_t d;
    logic [4:0] v;
    logic       hit;
    v   = '0;
    hit = 1'b0;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      v = 5'(c - CH_ZERO); hit = 1'b1;
    end else if (c >= CH_LA && c <= CH_LF) begin
      v = 5'(c - CH_LA) + 5'd10; hit = 1'b1;
    end else if (c >= CH_UA && c <= CH_UF) begin
      v = 5'(c - CH_UA) + 5'd10; hit = 1'b1;
    end
    d.val = v[3:0];
    d.ok  = hit && (b == BASE_OCT || b == BASE_DEC || b == BASE_HEX) && (v < b);
    return d;
  endfunction

  function automatic count_t bump(input count_t n);
    return (n < COUNT_MAX) ? n + count_t'(1) : n;
  endfunction

  // Configuration register
  base_t base_select;

  // Parse state
  logic [2:0] phase, phase_next;
  logic       is_negative, is_negative_next;
  base_t      active_base, active_base_next;
  logic [62:0] magnitude, magnitude_next;
  count_t     byte_count, byte_count_next;
  count_t     end_count, end_count_next;

  // Result register
  logic   res_valid;
  value_t res_value;
  count_t res_count;
  logic   res_ovf;

  logic   in_xfer;
  logic   emit, emit_ovf;
  logic   stop;
  char_t  c;
  digit_t dg;
  logic [67:0] prod;
  value_t value_out;

  // APB: single register, always ready
  assign pready = 1'b1;
  assign prdata = {27'd0, base_select};

  always_ff @(posedge clk) begin
    if (rst) begin
      base_select <= BASE_AUTO;
    end else if (psel && penable && pwrite && paddr[2] == REG_BASE_SELECT) begin
      base_select <= pwdata[BASE_W-1:0];
    end
  end

  // Take a byte whenever the result slot is empty or being drained
  assign in_ch.ready = !res_valid || out_ch.ready;
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign c           = in_ch.char_in;

  // One parse step, walking the phases the way a sequential parser falls through
  always_comb begin
    phase_next       = phase;
    is_negative_next = is_negative;
    active_base_next = active_base;
    magnitude_next   = magnitude;
    byte_count_next  = byte_count;
    end_count_next   = end_count;
    emit             = 1'b0;
    emit_ovf         = 1'b0;
    stop             = 1'b0;
    dg               = '0;
    prod             = '0;

    if (in_ch.start_string) begin
      phase_next       = PH_WS;
      is_negative_next = 1'b0;
      active_base_next = base_select;
      magnitude_next   = '0;
      byte_count_next  = '0;
      end_count_next   = '0;
    end else if (phase == PH_IDLE || phase == PH_DONE) begin
      stop = 1'b1;
    end

    // Leading whitespace, then an optional sign
    if (!stop && phase_next == PH_WS) begin
      if (c inside {[CH_TAB:CH_CR], CH_SPACE}) begin
        byte_count_next = bump(byte_count_next);
        stop = 1'b1;
      end else begin
        phase_next = PH_PREFIX;
        if (c == CH_MINUS || c == CH_PLUS) begin
          is_negative_next = (c == CH_MINUS);
          byte_count_next  = bump(byte_count_next);
          stop = 1'b1;
        end
      end
    end

    // Auto base: a leading zero may open an octal or hex prefix
    if (!stop && phase_next == PH_PREFIX) begin
      if (active_base_next == BASE_AUTO) begin
        if (c == CH_ZERO) begin
          byte_count_next = bump(byte_count_next);
          end_count_next  = byte_count_next;
          phase_next      = PH_ZERO;
          stop = 1'b1;
        end else begin
          active_base_next = BASE_DEC;
        end
      end
      if (!stop) begin
        phase_next = PH_DIGITS;
      end
    end

    if (!stop && phase_next == PH_ZERO) begin
      if (c == CH_LX || c == CH_UX) begin
        byte_count_next  = bump(byte_count_next);
        active_base_next = BASE_HEX;
        phase_next       = PH_DIGITS;
        stop = 1'b1;
      end else begin
        active_base_next = BASE_OCT;
        phase_next       = PH_DIGITS;
      end
    end

    // Digit: accumulate, or end the string on a non-digit or overflow
    if (!stop) begin
      dg = digit_of(c, active_base_next);
      case (active_base_next)
        BASE_HEX: prod = {1'b0, magnitude_next, 4'd0};
        BASE_OCT: prod = {2'b0, magnitude_next, 3'd0};
        default:  prod = {2'b0, magnitude_next, 3'd0} + {4'b0, magnitude_next, 1'b0};
      endcase
      prod = prod + 68'(dg.val);
      if (!dg.ok) begin
        emit       = 1'b1;
        phase_next = PH_DONE;
      end else if (prod[67:63] != 5'd0) begin
        emit       = 1'b1;
        emit_ovf   = 1'b1;
        phase_next = PH_DONE;
      end else begin
        magnitude_next  = prod[62:0];
        byte_count_next = bump(byte_count_next);
        end_count_next  = byte_count_next;
      end
    end
  end

  always_comb begin
    if (emit_ovf) begin
      value_out = is_negative_next ? NEG_MIN : POS_MAX;
    end else if (is_negative_next) begin
      value_out = 64'sd0 - value_t'({1'b0, magnitude_next});
    end else begin
      value_out = value_t'({1'b0, magnitude_next});
    end
  end

  // Advance parse state on every transferred byte
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      is_negative <= 1'b0;
      active_base <= BASE_AUTO;
      magnitude   <= '0;
      byte_count  <= '0;
      end_count   <= '0;
    end else if (in_xfer) begin
      phase       <= phase_next;
      is_negative <= is_negative_next;
      active_base <= active_base_next;
      magnitude   <= magnitude_next;
      byte_count  <= byte_count_next;
      end_count   <= end_count_next;
    end
  end

  // Result register: load on a stopping byte, drop once transferred
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (in_xfer && emit) begin
      res_valid <= 1'b1;
    end else if (out_ch.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && emit) begin
      res_value <= value_out;
      res_count <= end_count_next;
      res_ovf   <= emit_ovf;
    end
  end

  assign out_ch.valid          = res_valid;
  assign out_ch.parsed_value   = res_value;
  assign out_ch.consumed_count = res_count;
  assign out_ch.overflowed     = res_ovf;

endmodule : ascii_to_int64_parser_top

`default_nettype wire

FILE: verif/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for ascii_to_int64_parser_top. Text strings are fed
// one byte per transfer; a cycle-free model of the strtoll-style parse
// predicts each result, and every result transfer is checked field by field
// against the oldest prediction. Directed strings cover prefixes, signs,
// bases, overflow and count saturation; random strings follow.
// ---------------------------------------------------------------------------
module tb;
  import a2i_pkg::*;

  // Parse progress of the prediction, one step per byte
  typedef enum logic [2:0] {
    ST_IDLE, ST_BLANKS, ST_SIGN, ST_LEAD_ZERO, ST_DIGITS, ST_DONE
  } parse_state_t;

  typedef struct {
    value_t value;
    count_t count;
    logic   ovf;
  } parse_result_t;

  localparam logic [2:0]  ADDR_BASE_SELECT = 3'd0;
  localparam char_t       NUL              = 8'h00;
  localparam logic [4:0]  NOT_DIGIT        = 5'd31;
  localparam logic [63:0] POS_MAX          = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] NEG_MIN          = 64'h8000_0000_0000_0000;
  localparam base_t       BASE_AUTO        = 5'd0;
  localparam base_t       BASE_OCT         = 5'd8;
  localparam base_t       BASE_DEC         = 5'd10;
  localparam base_t       BASE_HEX         = 5'd16;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  a2i_in_if  in_ch ();
  a2i_out_if out_ch ();

  ascii_to_int64_parser_top u_dut (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Prediction state: the bench's own copy of the register and parse state
  base_t         base_now   = BASE_AUTO;
  parse_state_t  pstate     = ST_IDLE;
  logic          neg        = 1'b0;
  base_t         radix      = BASE_AUTO;
  logic [63:0]   mag        = '0;
  int unsigned   taken      = 0;
  int unsigned   end_pos    = 0;

  parse_result_t pending[$];
  parse_result_t want;
  int            fail_count = 0;
  int unsigned   bytes_sent = 0;
  bit            gaps_on    = 1'b1;
  bit            stall_on   = 1'b1;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case a handshake never completes
  initial begin
    #20_000_000;
    $display("tb NOT OK");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------
  function automatic logic is_blank(input char_t c);
    return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic logic [4:0] digit_value(input char_t c, input base_t r);
    logic [4:0] d;
    d = NOT_DIGIT;
    if (c >= "0" && c <= "9") d = 5'(c - "0");
    else if (c >= "a" && c <= "f") d = 5'(c - "a" + 10);
    else if (c >= "A" && c <= "F") d = 5'(c - "A" + 10);
    if (r != BASE_OCT && r != BASE_DEC && r != BASE_HEX) d = NOT_DIGIT;
    else if (d >= r) d = NOT_DIGIT;
    return d;
  endfunction

  task automatic count_byte();
    if (taken < MAX_CHARS) taken++;
  endtask

  task automatic close_string(input logic ovf);
    parse_result_t r;
    r.ovf = ovf;
    if (ovf) r.value = neg ? NEG_MIN : POS_MAX;
    else r.value = neg ? -mag : mag;
    r.count = count_t'(end_pos);
    pending.push_back(r);
    pstate = ST_DONE;
  endtask

  // Advance the parse by one transferred byte; a stopping byte queues a result
  task automatic track_byte(input char_t c, input logic first);
    logic [4:0] d;
    if (first) begin
      pstate  = ST_BLANKS;
      neg     = 1'b0;
      radix   = base_now;
      mag     = '0;
      taken   = 0;
      end_pos = 0;
    end else if (pstate == ST_IDLE || pstate == ST_DONE) begin
      return;
    end
    if (pstate == ST_BLANKS) begin
      if (is_blank(c)) begin
        count_byte();
        return;
      end
      pstate = ST_SIGN;
      if (c == "-" || c == "+") begin
        neg = (c == "-");
        count_byte();
        return;
      end
    end
    if (pstate == ST_SIGN) begin
      if (radix == BASE_AUTO) begin
        // a lone leading zero is already a valid number
        if (c == "0") begin
          count_byte();
          end_pos = taken;
          pstate  = ST_LEAD_ZERO;
          return;
        end
        radix = BASE_DEC;
      end
      pstate = ST_DIGITS;
    end
    if (pstate == ST_LEAD_ZERO) begin
      if (c == "x" || c == "X") begin
        count_byte();
        radix  = BASE_HEX;
        pstate = ST_DIGITS;
        return;
      end
      radix  = BASE_OCT;
      pstate = ST_DIGITS;
    end
    d = digit_value(c, radix);
    if (d == NOT_DIGIT) begin
      close_string(1'b0);
    end else if (mag > (POS_MAX - d) / radix) begin
      close_string(1'b1);
    end else begin
      mag = mag * radix + d;
      count_byte();
      end_pos = taken;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result checking: compare every result transfer with the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending.size() == 0) begin
        $error("unexpected result: parsed_value %0d consumed_count %0d overflowed %0b",
               out_ch.parsed_value, out_ch.consumed_count, out_ch.overflowed);
        fail_count++;
      end else begin
        want = pending.pop_front();
        if (out_ch.parsed_value !== want.value) begin
          $error("parsed_value: expected %0d, got %0d", want.value, out_ch.parsed_value);
          fail_count++;
        end
        if (out_ch.consumed_count !== want.count) begin
          $error("consumed_count: expected %0d, got %0d", want.count,
                 out_ch.consumed_count);
          fail_count++;
        end
        if (out_ch.overflowed !== want.ovf) begin
          $error("overflowed: expected %0b, got %0b", want.ovf, out_ch.overflowed);
          fail_count++;
        end
      end
    end
  end

  // Result side back-pressure: hold ready low in bursts of random length
  always begin
    @(posedge clk);
    if (stall_on && $urandom_range(0, 5) == 0) begin
      out_ch.ready <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    out_ch.ready <= 1'b1;
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Offer one byte and wait for its transfer; an optional gap goes first.
  // valid stays high afterwards so a following byte can go back to back.
  task automatic send_item(input char_t c, input logic first);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.char_in      <= c;
    in_ch.start_string <= first;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    track_byte(c, first);
    bytes_sent++;
  endtask

  // Send a byte sequence with the start flag on its first byte only
  task automatic send_text(input char_t text[$]);
    foreach (text[i]) send_item(text[i], i == 0);
  endtask

  // Send a string followed by its terminator
  task automatic send_word(input string s);
    char_t text[$];
    foreach (s[i]) text.push_back(s[i]);
    text.push_back(NUL);
    send_text(text);
  endtask

  // Let the parser go idle, then program base_select with an APB write
  task automatic write_base(input base_t b);
    in_ch.valid <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
    // trailing ignored bytes may still be in flight: give them time to drain
    repeat (4) @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_BASE_SELECT;
    pwdata  <= 32'(b);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    base_now = b;
  endtask

  function automatic char_t blank_char();
    int k;
    k = $urandom_range(0, 5);
    return (k == 5) ? 8'h20 : char_t'(9 + k);
  endfunction

  function automatic char_t digit_char(input base_t r);
    int v;
    v = $urandom_range(0, r - 1);
    if (v < 10) return char_t'("0" + v);
    return char_t'(($urandom_range(0, 1) ? "a" : "A") + v - 10);
  endfunction

  function automatic base_t pick_base();
    case ($urandom_range(0, 9))
      0, 1, 2: return BASE_AUTO;
      3:       return BASE_OCT;
      4, 5:    return BASE_DEC;
      6, 7:    return BASE_HEX;
      default: return base_t'($urandom_range(0, 31));
    endcase
  endfunction

  // Mostly well-formed numbers with random content; the rest is raw noise
  // or a string abandoned by a restart before its terminator.
  task automatic send_random_string();
    char_t text[$];
    int    kind;
    int    n;
    base_t r;
    kind = $urandom_range(0, 9);
    if (kind == 9) begin
      repeat ($urandom_range(1, 4)) text.push_back(digit_char(BASE_DEC));
      send_text(text);
      text.delete();
    end
    if (kind == 7 || kind == 8) begin
      repeat ($urandom_range(1, 6)) text.push_back(char_t'($urandom_range(0, 255)));
      text.push_back(NUL);
    end else begin
      repeat ($urandom_range(0, 3)) text.push_back(blank_char());
      case ($urandom_range(0, 2))
        1: text.push_back("+");
        2: text.push_back("-");
        default: ;
      endcase
      r = base_now;
      if (base_now == BASE_AUTO) begin
        case ($urandom_range(0, 2))
          0: begin
            text.push_back("0");
            text.push_back($urandom_range(0, 1) ? "x" : "X");
            r = BASE_HEX;
          end
          1: begin
            text.push_back("0");
            r = BASE_OCT;
          end
          default: r = BASE_DEC;
        endcase
      end else if (base_now == BASE_HEX && $urandom_range(0, 4) == 0) begin
        text.push_back("0");
        text.push_back("x");
      end
      if (r != BASE_OCT && r != BASE_DEC && r != BASE_HEX) r = BASE_DEC;
      // long runs reach the overflow boundary in every base
      n = ($urandom_range(0, 3) == 0) ? $urandom_range(15, 25) : $urandom_range(0, 8);
      repeat (n) text.push_back(digit_char(r));
      case ($urandom_range(0, 3))
        0: text.push_back(NUL);
        1: begin
          text.push_back(char_t'($urandom_range(0, 255)));
          text.push_back(NUL);
        end
        2: begin
          // bytes after the terminator must be ignored
          text.push_back(NUL);
          repeat ($urandom_range(1, 3)) text.push_back(char_t'($urandom_range(0, 255)));
        end
        default: begin
          text.push_back(char_t'($urandom_range(8'h20, 8'h7E)));
          text.push_back(NUL);
        end
      endcase
    end
    send_text(text);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Bytes before any start, after a result, and a restart mid-string
  task automatic test_ignored_bytes();
    send_item("7", 1'b0);
    send_item(NUL, 1'b0);
    send_word("5");
    send_item("9", 1'b0);
    send_item(NUL, 1'b0);
    send_item("1", 1'b1);
    send_item("2", 1'b0);
    send_word("34");
  endtask

  // Base detection from the prefix, bare hex prefix and strings with no digits
  task automatic test_auto_base();
    write_base(BASE_AUTO);
    send_word("0x1F");
    send_word("0Xa");
    send_word("0xg");
    send_word("017");
    send_word("08");
    send_word("0");
    send_word("");
    send_word("-0");
    send_word("12 34");
    send_word("abc");
    send_item(8'hFF, 1'b1);
    send_item(NUL, 1'b0);
  endtask

  // Every whitespace byte, then the sign forms
  task automatic test_blanks_and_sign();
    send_item(8'h20, 1'b1);
    for (int c = 9; c <= 13; c++) send_item(char_t'(c), 1'b0);
    send_item("-", 1'b0);
    send_item("4", 1'b0);
    send_item("2", 1'b0);
    send_item(NUL, 1'b0);
    send_word("+7");
    send_word(" -");
    send_word("+-3");
  endtask

  // Fixed bases: no prefix skipping, so an 'x' ends the number
  task automatic test_explicit_bases();
    write_base(BASE_HEX);
    send_word("0x10");
    send_word("dEaDbEeF");
    send_word("-Ab");
    write_base(BASE_OCT);
    send_word("777");
    send_word("8");
    send_word("-17");
    write_base(BASE_DEC);
    send_word("0x5");
    send_word("0123");
    send_word("-99z");
  endtask

  // Unsupported bases accept no digit at all
  task automatic test_other_bases();
    base_t odd[$] = '{5'd1, 5'd2, 5'd9, 5'd17, 5'd31};
    foreach (odd[i]) begin
      write_base(odd[i]);
      send_word(" -5");
      send_word("0x1");
    end
  endtask

  // Saturation at both ends of the 64-bit range
  task automatic test_overflow();
    write_base(BASE_AUTO);
    send_word("9223372036854775807");
    send_word("9223372036854775808");
    send_word("-9223372036854775807");
    send_word("-9223372036854775808");
    send_word("-9223372036854775809");
    send_word("0x7fffffffffffffff");
    send_word("0x8000000000000000");
    send_word("-0x8000000000000000");
    send_word("01777777777777777777777");
    send_word("99999999999999999999999");
  endtask

  // Strings longer than MAX_CHARS: the consumed count must stick at the limit
  task automatic test_count_saturation();
    char_t text[$];
    write_base(BASE_DEC);
    repeat (MAX_CHARS + 4) text.push_back(8'h20);
    text.push_back("5");
    text.push_back(NUL);
    send_text(text);
    text.delete();
    repeat (MAX_CHARS + 4) text.push_back("0");
    text.push_back("7");
    text.push_back(NUL);
    send_text(text);
  endtask

  // Random strings; the base and the idling pattern change every 30 strings
  task automatic test_random_strings();
    int unsigned stop_at;
    int          strings;
    stop_at = bytes_sent + 1300;
    strings = 0;
    while (bytes_sent < stop_at) begin
      if (strings % 30 == 0) begin
        write_base(pick_base());
        gaps_on  = $urandom_range(0, 3) != 0;
        stall_on = $urandom_range(0, 3) != 0;
      end
      send_random_string();
      strings++;
    end
  endtask

  // Full rate on both sides to close the run
  task automatic test_back_to_back();
    gaps_on  = 1'b0;
    stall_on = 1'b0;
    write_base(BASE_AUTO);
    repeat (15) send_random_string();
    write_base(BASE_HEX);
    repeat (10) send_random_string();
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst                <= 1'b1;
    in_ch.valid        <= 1'b0;
    in_ch.char_in      <= NUL;
    in_ch.start_string <= 1'b0;
    out_ch.ready       <= 1'b0;
    psel               <= 1'b0;
    penable            <= 1'b0;
    pwrite             <= 1'b0;
    paddr              <= ADDR_BASE_SELECT;
    pwdata             <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    test_ignored_bytes();
    test_auto_base();
    test_blanks_and_sign();
    test_explicit_bases();
    test_other_bases();
    test_overflow();
    test_count_saturation();
    test_random_strings();
    test_back_to_back();

    // Drop valid, wait for the last results, then allow for the result stage
    in_ch.valid <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule : tb

FILE: filelist.f
rtl/core/a2i_pkg.sv
rtl/core/a2i_if.sv
rtl/core/ascii_to_int64_parser_top.sv
verif/tb.sv
